// ----- design/civil_date_to_epoch_seconds_unit_defines.svh -----
// assertion macros for the calendar date to epoch seconds unit
`ifndef CIVIL_DATE_TO_EPOCH_SECONDS_UNIT_DEFINES_SVH
`define CIVIL_DATE_TO_EPOCH_SECONDS_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define CDES_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define CDES_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define CDES_ASSERT_IMPL(label, clk, rst, ante, cons)
`define CDES_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ----- design/cdes_pkg.sv -----
package cdes_pkg;

   localparam int YEAR_MIN = 1970;
   localparam int YEAR_MAX = 9999;
   localparam int MONTH_MAX = 11;
   localparam int MONTH_FEB = 1;
   localparam int DAYS_PER_YEAR = 365;
   localparam int MINUTES_PER_HOUR = 60;
   localparam int SECONDS_PER_MINUTE = 60;
   localparam int SECONDS_PER_DAY = 24 * 60 * 60;

   // floor(b / 100) = (b * DIV100_MULT) >> DIV100_SHIFT, exact for b below 43690
   localparam int DIV100_MULT = 5243;
   localparam int DIV100_SHIFT = 19;

   // leap days counted up to the year before the epoch
   localparam int LEAP_BASE = (YEAR_MIN - 1) / 4 - (YEAR_MIN - 1) / 100
                              + (YEAR_MIN - 1) / 400;

   localparam int NUM_STAGES = 5;

   typedef struct packed {
      logic [21:0] year_days;
      logic [10:0] leap_count;
      logic [8:0]  month_days;
      logic [4:0]  day_of_month;
      logic [10:0] minute_of_day;
      logic [5:0]  sec_of_minute;
   } front_out_type;

   function automatic logic [8:0] days_before_month(input logic [3:0] month);
      logic [8:0] days;
      case (month)
         4'd0:    days = 9'd0;
         4'd1:    days = 9'd31;
         4'd2:    days = 9'd59;
         4'd3:    days = 9'd90;
         4'd4:    days = 9'd120;
         4'd5:    days = 9'd151;
         4'd6:    days = 9'd181;
         4'd7:    days = 9'd212;
         4'd8:    days = 9'd243;
         4'd9:    days = 9'd273;
         4'd10:   days = 9'd304;
         default: days = 9'd334;
      endcase
      return days;
   endfunction

endpackage

// ----- design/cdes_front.sv -----
module cdes_front (
   input  logic                      clock,
   input  logic [1:0]                stage_ld,
   input  logic [13:0]               year,
   input  logic [3:0]                month,
   input  logic [4:0]                day_of_month,
   input  logic [4:0]                hour,
   input  logic [5:0]                minute,
   input  logic [5:0]                second,
   output cdes_pkg::front_out_type   front_out
);

   // stage 1: clamp, year minus one, reciprocal product for the divide by 100
   logic [13:0] year_clamped;
   logic [13:0] s1_prev_year_in, s1_prev_year_ff;
   logic [12:0] s1_year_off_in, s1_year_off_ff;
   logic [25:0] s1_prod_in, s1_prod_ff;
   logic [3:0]  s1_month_in, s1_month_ff;
   logic [4:0]  s1_dom_ff;
   logic [4:0]  s1_hour_ff;
   logic [5:0]  s1_minute_ff;
   logic [5:0]  s1_second_ff;

   always_comb begin
      if (year < 14'(cdes_pkg::YEAR_MIN)) begin
         year_clamped = 14'(cdes_pkg::YEAR_MIN);
      end else if (year > 14'(cdes_pkg::YEAR_MAX)) begin
         year_clamped = 14'(cdes_pkg::YEAR_MAX);
      end else begin
         year_clamped = year;
      end
      if (month > 4'(cdes_pkg::MONTH_MAX)) begin
         s1_month_in = 4'(cdes_pkg::MONTH_MAX);
      end else begin
         s1_month_in = month;
      end
      s1_prev_year_in = year_clamped - 14'd1;
      s1_year_off_in  = 13'(year_clamped - 14'(cdes_pkg::YEAR_MIN));
      s1_prod_in      = 26'(s1_prev_year_in) * 26'(cdes_pkg::DIV100_MULT);
   end

   always_ff @(posedge clock) begin
      if (stage_ld[0]) begin
         s1_prev_year_ff <= s1_prev_year_in;
         s1_year_off_ff  <= s1_year_off_in;
         s1_prod_ff      <= s1_prod_in;
         s1_month_ff     <= s1_month_in;
         s1_dom_ff       <= day_of_month;
         s1_hour_ff      <= hour;
         s1_minute_ff    <= minute;
         s1_second_ff    <= second;
      end
   end

   // stage 2: leap count and flag, year and month day counts, minute of day
   logic [6:0]  q100;
   logic [4:0]  q400;
   logic [11:0] q4;
   logic [13:0] rem_wide;
   logic [6:0]  r100;
   logic        is_leap;
   logic [12:0] leap_wide;
   cdes_pkg::front_out_type s2_in, s2_ff;

   always_comb begin
      q100     = s1_prod_ff[cdes_pkg::DIV100_SHIFT +: 7];
      q400     = q100[6:2];
      q4       = s1_prev_year_ff[13:2];
      rem_wide = s1_prev_year_ff - 14'(q100) * 14'd100;
      r100     = rem_wide[6:0];
      // the year itself is leap when year minus one ends in 3 mod 4,
      // and the century test runs on year minus one as well
      is_leap  = (s1_prev_year_ff[1:0] == 2'b11) &&
                 ((r100 != 7'd99) || (q100[1:0] == 2'b11));
      leap_wide = 13'(q4) + 13'(q400) - 13'(q100) - 13'(cdes_pkg::LEAP_BASE);

      s2_in.year_days     = 22'(s1_year_off_ff) * 22'(cdes_pkg::DAYS_PER_YEAR);
      s2_in.leap_count    = leap_wide[10:0];
      s2_in.month_days    = cdes_pkg::days_before_month(s1_month_ff) +
                            9'(is_leap && (s1_month_ff > 4'(cdes_pkg::MONTH_FEB)));
      s2_in.day_of_month  = s1_dom_ff;
      s2_in.minute_of_day = 11'(s1_hour_ff) * 11'(cdes_pkg::MINUTES_PER_HOUR) +
                            11'(s1_minute_ff);
      s2_in.sec_of_minute = s1_second_ff;
   end

   always_ff @(posedge clock) begin
      if (stage_ld[1]) begin
         s2_ff <= s2_in;
      end
   end

   assign front_out = s2_ff;

endmodule

// ----- design/cdes_back.sv -----
module cdes_back (
   input  logic                     clock,
   input  logic [2:0]               stage_ld,
   input  cdes_pkg::front_out_type  front_out,
   output logic [37:0]              epoch_seconds
);

   // stage 3: day count plus one (never negative) and seconds of the day
   logic [21:0] s3_days_p1_in, s3_days_p1_ff;
   logic [16:0] s3_tod_in, s3_tod_ff;

   always_comb begin
      s3_days_p1_in = front_out.year_days + 22'(front_out.leap_count) +
                      22'(front_out.month_days) + 22'(front_out.day_of_month);
      s3_tod_in     = 17'(front_out.minute_of_day) * 17'(cdes_pkg::SECONDS_PER_MINUTE) +
                      17'(front_out.sec_of_minute);
   end

   always_ff @(posedge clock) begin
      if (stage_ld[0]) begin
         s3_days_p1_ff <= s3_days_p1_in;
         s3_tod_ff     <= s3_tod_in;
      end
   end

   // stage 4: whole days to seconds; day minus one only for day zero of 1970
   logic [37:0] s4_day_sec_in, s4_day_sec_ff;
   logic        s4_neg_day_in, s4_neg_day_ff;
   logic [16:0] s4_tod_ff;

   always_comb begin
      s4_neg_day_in = (s3_days_p1_ff == 22'd0);
      s4_day_sec_in = 38'(s3_days_p1_ff - 22'd1) * 38'(cdes_pkg::SECONDS_PER_DAY);
   end

   always_ff @(posedge clock) begin
      if (stage_ld[1]) begin
         s4_day_sec_ff <= s4_day_sec_in;
         s4_neg_day_ff <= s4_neg_day_in;
         s4_tod_ff     <= s3_tod_ff;
      end
   end

   // stage 5: final sum, saturating at zero before the epoch
   logic [37:0] s5_epoch_in, s5_epoch_ff;

   always_comb begin
      if (s4_neg_day_ff) begin
         if (s4_tod_ff > 17'(cdes_pkg::SECONDS_PER_DAY)) begin
            s5_epoch_in = 38'(s4_tod_ff - 17'(cdes_pkg::SECONDS_PER_DAY));
         end else begin
            s5_epoch_in = 38'd0;
         end
      end else begin
         s5_epoch_in = s4_day_sec_ff + 38'(s4_tod_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (stage_ld[2]) begin
         s5_epoch_ff <= s5_epoch_in;
      end
   end

   assign epoch_seconds = s5_epoch_ff;

endmodule

// ----- design/civil_date_to_epoch_seconds_unit.sv -----
// Converts one broken-down UTC date and time of day into seconds since
// 1970-01-01 00:00:00 UTC. Years are clamped to 1970..9999 and the month
// index to 0..11; day, hour, minute and second are used at full weight
// without range checks, and a result that would fall before the epoch
// reads as zero. The unit is a five-stage pipeline: a transaction is
// accepted every cycle that req_ready is high and its result comes out
// on the rsp_ channel. Each stage holds its data while the stage after
// it is full and stalled, so a stalled result does not stop the upstream
// stages from filling their empty slots; req_ready drops only once all
// five stages hold a transaction and the output is not being taken.

`include "civil_date_to_epoch_seconds_unit_defines.svh"

module civil_date_to_epoch_seconds_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [13:0] req_year,
   input  logic [3:0]  req_month,
   input  logic [4:0]  req_day_of_month,
   input  logic [4:0]  req_hour,
   input  logic [5:0]  req_minute,
   input  logic [5:0]  req_second,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [37:0] rsp_epoch_seconds
);

   localparam int NS = cdes_pkg::NUM_STAGES;

   // one valid bit per stage, travelling with the data
   logic [NS-1:0] valid_ff;
   logic [NS-1:0] valid_in;
   // per-stage load: a stage takes new data when empty or when it moves on
   logic [NS-1:0] stage_ld;

   always_comb begin
      stage_ld[NS-1] = !valid_ff[NS-1] || rsp_ready;
      for (int k = NS - 2; k >= 0; k--) begin
         stage_ld[k] = !valid_ff[k] || stage_ld[k+1];
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (stage_ld[0]) begin
         valid_in[0] = req_valid;
      end
      for (int k = 1; k < NS; k++) begin
         if (stage_ld[k]) begin
            valid_in[k] = valid_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_ready = stage_ld[0];
   assign rsp_valid = valid_ff[NS-1];

   // year split, leap count and day tables
   cdes_pkg::front_out_type front_out;

   cdes_front u_front (
      .clock        (clock),
      .stage_ld     (stage_ld[1:0]),
      .year         (req_year),
      .month        (req_month),
      .day_of_month (req_day_of_month),
      .hour         (req_hour),
      .minute       (req_minute),
      .second       (req_second),
      .front_out    (front_out)
   );

   // day total, seconds scaling and final sum into the output register
   cdes_back u_back (
      .clock         (clock),
      .stage_ld      (stage_ld[NS-1:2]),
      .front_out     (front_out),
      .epoch_seconds (rsp_epoch_seconds)
   );

   // an empty output stage leaves the whole pipe free to take input
   `CDES_ASSERT_IMPL(a_ready_when_out_free, clock, reset, !rsp_valid, req_ready)
   // an accepted transaction lands in the first stage
   `CDES_ASSERT_NEXT(a_accept_fills_first, clock, reset, req_valid && req_ready, valid_ff[0])
   // a full pipe with a stalled output refuses input
   `CDES_ASSERT_IMPL(a_full_stall_blocks, clock, reset, (&valid_ff) && !rsp_ready, !req_ready)

endmodule
